// ===== rtl/core/cffg_pkg.sv =====
package cffg_pkg;

  // Field widths
  localparam int SAMPLE_W = 16;
  localparam int DIFF_W   = SAMPLE_W + 1;
  localparam int FLOW_W   = 31;
  localparam int FW_W     = 11;
  localparam int FH_W     = 16;
  localparam int TDATA_IN_W  = 32;
  localparam int TDATA_OUT_W = 64;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  // Register reset values
  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd1024;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 16'd1024;

  localparam int MAX_WIDTH_DEF = 1024;

  // Per-beat control carried from accept into the memory-read stage
  typedef struct packed {
    logic emit;       // beat produces a result
    logic wr;         // beat writes the line buffers (pixel beat)
    logic has_up;     // row above exists
    logic has_down;   // row below is the incoming pixel
    logic left_ok;    // not the first column
    logic right_ok;   // not the last column
    logic fend;       // last result of the frame
  } s1_ctrl_t;

endpackage

// ===== rtl/core/contour_flow_from_gradient.sv =====
// contour_flow_from_gradient
//
// Streams a raster of pixels in on s_* and returns per-pixel contour flow on m_*.
// Input beat: s_tdata = {contour_sample, scale_sample} (Q3.12 each), s_tuser = drain.
// Output beat: m_tdata = {2'b0, flow_y, flow_x} (24 fraction bits), m_tlast = frame_end.
// cfg_* writes frame_width (index 0) or frame_height (index 1); any write restarts
// the frame. Write config only while the block is idle; cfg_ready is always high.
//
// Results lag one row: the pixel below completes a result. A frame's last row is
// flushed by drain beats, one result each. Pixel beats sent while flush results are
// still owed are dropped.
// Throughput: one beat per cycle while the output is not stalled, set by the single
// read/write pass through the three line buffers (one write port, centre contour read at x and x+1).
// A completing beat's buffer read is registered in the read stage, its differences in
// the multiply stage and its products in the output register, which drives m_*.
// Reset: positions and flush count clear, registers go to 1024 x 1024; the line
// buffers are not cleared. When m_tready is low the pipeline keeps taking beats
// until its three stages are full, then s_tready drops.
module contour_flow_from_gradient import cffg_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [TDATA_IN_W-1:0]  s_tdata,   // [15:0] scale_sample, [31:16] contour_sample
  input  logic                   s_tuser,   // [0] drain
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [TDATA_OUT_W-1:0] m_tdata,   // [30:0] flow_x, [61:31] flow_y, [63:62] zero
  output logic                   m_tlast,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int CW = (WW > FW_W) ? WW : FW_W;
  localparam logic [CW-1:0] MAXW_C = CW'(MAX_WIDTH);

  // Registers and frame position
  logic [FW_W-1:0] frame_width;
  logic [FH_W-1:0] frame_height;
  logic [AW-1:0]   col;
  logic [FH_W-1:0] row;
  logic [WW-1:0]   pend;

  // Line buffers
  logic signed [SAMPLE_W-1:0] cc_mem [MAX_WIDTH];   // centre row contour
  logic signed [SAMPLE_W-1:0] cs_mem [MAX_WIDTH];   // centre row scale
  logic signed [SAMPLE_W-1:0] up_mem [MAX_WIDTH];   // upper row contour

  // Accept stage
  logic [WW-1:0]   eff_w;
  logic [CW-1:0]   fw_ext;
  logic [FH_W-1:0] eff_h;
  logic            drain;
  logic signed [SAMPLE_W-1:0] scale_in, contour_in;
  logic            in_fire, cfg_fire, enter, pend_bad;
  logic [AW-1:0]   col_c, x0, ra1;
  logic [FH_W-1:0] row_c;
  logic [FH_W:0]   row_inc;
  logic [WW-1:0]   xw1;
  s1_ctrl_t        ctl0;

  // Read stage
  logic            s1_valid, s1_adv, s1_leave, mem_we;
  s1_ctrl_t        s1_ctl;
  logic [AW-1:0]   s1_x;
  logic signed [SAMPLE_W-1:0] s1_down, s1_scale;
  logic signed [SAMPLE_W-1:0] rd_c, rd_r, rd_s, rd_u, byp_c, byp_s, byp_u, left_q;
  logic            hit_c, hit_r;
  logic signed [SAMPLE_W-1:0] c_cur, r_cur, s_cur, u_cur;
  logic signed [SAMPLE_W-1:0] nb_l, nb_r, nb_u, nb_d;
  logic signed [DIFF_W-1:0]   dx, dy;

  // Multiply stage
  logic            s2_valid, s2_adv, s2_zero, s2_fend;
  logic signed [DIFF_W-1:0]   s2_dx, s2_dy;
  logic signed [SAMPLE_W-1:0] s2_s;
  logic signed [DIFF_W+SAMPLE_W-1:0] px, py;

  // Output register
  logic            out_adv;
  logic [FLOW_W-1:0] flow_x, flow_y;
  logic            frame_end;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid & cfg_ready;

  assign fw_ext = CW'(frame_width);
  assign eff_w  = (fw_ext == '0) ? WW'(1) : (fw_ext > MAXW_C) ? WW'(MAX_WIDTH) : WW'(fw_ext);
  assign eff_h  = (frame_height == '0) ? FH_W'(1) : frame_height;

  assign scale_in   = s_tdata[SAMPLE_W-1:0];
  assign contour_in = s_tdata[2*SAMPLE_W-1:SAMPLE_W];
  assign drain      = s_tuser;

  assign out_adv  = ~m_tvalid | m_tready;
  assign s2_adv   = ~s2_valid | out_adv;
  assign s1_adv   = ~s1_valid | ~s1_ctl.emit | s2_adv;
  assign s1_leave = s1_valid & s1_adv;
  assign mem_we   = s1_leave & s1_ctl.wr;
  assign s_tready = s1_adv;
  assign in_fire  = s_tvalid & s_tready;

  always_comb begin
    pend_bad = (pend == '0) || (pend > eff_w);
    col_c    = (WW'(col) >= eff_w) ? '0 : col;
    row_c    = (row >= eff_h) ? '0 : row;
    row_inc  = {1'b0, row_c} + 1'b1;
    x0       = drain ? AW'(eff_w - pend) : col_c;
    xw1      = WW'(x0) + 1'b1;
    ra1      = AW'(xw1);
    enter    = in_fire & (drain ? ~pend_bad : (pend == '0));
    ctl0.emit     = drain | (row_c != '0);
    ctl0.wr       = ~drain;
    ctl0.has_up   = drain ? (eff_h > FH_W'(1)) : (row_c >= FH_W'(2));
    ctl0.has_down = ~drain;
    ctl0.left_ok  = (x0 != '0);
    ctl0.right_ok = (xw1 < eff_w);
    ctl0.fend     = drain & (pend == WW'(1));
  end

  // Registers, raster position, flush count
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
      col  <= '0;
      row  <= '0;
      pend <= '0;
    end else if (cfg_fire) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[FH_W-1:0];
        default: ;
      endcase
      col  <= '0;
      row  <= '0;
      pend <= '0;
    end else if (in_fire) begin
      if (drain) begin
        pend <= pend_bad ? '0 : pend - 1'b1;
      end else if (pend == '0) begin
        if (xw1 >= eff_w) begin
          col <= '0;
          if (row_inc >= {1'b0, eff_h}) begin
            row  <= '0;
            pend <= eff_w;
          end else begin
            row <= row_inc[FH_W-1:0];
          end
        end else begin
          col <= ra1;
          row <= row_c;
        end
      end
    end
  end

  // Line buffers: one write from the read stage, reads issued at accept.
  // A read hitting the entry written on the same edge takes the new data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      cc_mem[s1_x] <= s1_down;
      cs_mem[s1_x] <= s1_scale;
      up_mem[s1_x] <= c_cur;
    end
    if (enter) begin
      rd_c  <= cc_mem[x0];
      rd_r  <= cc_mem[ra1];
      rd_s  <= cs_mem[x0];
      rd_u  <= up_mem[x0];
      hit_c <= mem_we & (s1_x == x0);
      hit_r <= mem_we & (s1_x == ra1);
      byp_c <= s1_down;
      byp_s <= s1_scale;
      byp_u <= c_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (enter) begin
      s1_valid <= 1'b1;
    end else if (s1_leave) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (enter) begin
      s1_ctl   <= ctl0;
      s1_x     <= x0;
      s1_down  <= contour_in;
      s1_scale <= scale_in;
    end
    if (s1_leave) begin
      left_q <= c_cur;   // previous column's centre contour, before overwrite
    end
  end

  // Neighbor selection and differences
  always_comb begin
    c_cur = hit_c ? byp_c : rd_c;
    s_cur = hit_c ? byp_s : rd_s;
    u_cur = hit_c ? byp_u : rd_u;
    r_cur = hit_r ? byp_c : rd_r;
    nb_l  = (s1_ctl.left_ok  && left_q  > 0) ? left_q  : c_cur;
    nb_r  = (s1_ctl.right_ok && r_cur   > 0) ? r_cur   : c_cur;
    nb_u  = (s1_ctl.has_up   && u_cur   > 0) ? u_cur   : c_cur;
    nb_d  = (s1_ctl.has_down && s1_down > 0) ? s1_down : c_cur;
    dy    = DIFF_W'(nb_u) - DIFF_W'(nb_d);
    dx    = DIFF_W'(nb_r) - DIFF_W'(nb_l);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_adv) begin
      s2_valid <= s1_valid & s1_ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s1_valid && s1_ctl.emit) begin
      s2_dx   <= dx;
      s2_dy   <= dy;
      s2_s    <= s_cur;
      s2_zero <= ~((s_cur > 0) && (c_cur > 0));
      s2_fend <= s1_ctl.fend;
    end
  end

  // Products fit in 31 bits: |diff| < 2^15, scale < 2^15
  assign px = s2_dy * s2_s;
  assign py = s2_dx * s2_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_adv) begin
      m_tvalid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s2_valid) begin
      flow_x    <= s2_zero ? '0 : px[FLOW_W-1:0];
      flow_y    <= s2_zero ? '0 : py[FLOW_W-1:0];
      frame_end <= s2_fend;
    end
  end

  assign m_tdata = {(TDATA_OUT_W - 2*FLOW_W)'(0), flow_y, flow_x};
  assign m_tlast = frame_end;

endmodule
